>>> sv/ecd_pkg.sv
`timescale 1ns / 1ps

package ecd_pkg;

  // calendar constants
  localparam logic [31:0] LAST_SECOND     = 32'd4102444799;
  localparam logic [11:0] BASE_YEAR       = 12'd1970;
  localparam logic [11:0] LAST_YEAR       = 12'd2099;
  localparam logic [3:0]  LAST_MONTH      = 4'd11;
  localparam logic [4:0]  LAST_DAY        = 5'd30;
  localparam logic [4:0]  LAST_HOUR       = 5'd23;
  localparam logic [5:0]  LAST_MINSEC     = 6'd59;
  localparam logic [5:0]  MONTHS_PER_YEAR = 6'd12;
  localparam int          CYCLE_MONTHS    = 48;
  localparam logic [16:0] SECS_PER_DAY    = 17'd86400;
  localparam logic [10:0] DAYS_PER_CYCLE  = 11'd1461;
  localparam logic [11:0] SECS_PER_HOUR   = 12'd3600;
  localparam logic [5:0]  SECS_PER_MIN    = 6'd60;

  // reciprocals for constant division, exact over the ranges in use
  // seconds >> 7, then divide by 675
  localparam logic [25:0] DAY_RECIP  = 26'd50903317;
  localparam int          DAY_SHIFT  = 35;
  // days (< 47482) divided by 1461
  localparam logic [16:0] CYC_RECIP  = 17'd91868;
  localparam int          CYC_SHIFT  = 27;
  // time of day >> 4, then divide by 225
  localparam logic [13:0] HOUR_RECIP = 14'd9321;
  localparam int          HOUR_SHIFT = 21;
  // seconds of hour >> 2, then divide by 15
  localparam logic [10:0] MIN_RECIP  = 11'd1093;
  localparam int          MIN_SHIFT  = 14;

  // first day of each month inside the four-year cycle, third year leap
  localparam logic [10:0] MONTH_START [CYCLE_MONTHS] = '{
    11'd0,    11'd31,   11'd59,   11'd90,   11'd120,  11'd151,
    11'd181,  11'd212,  11'd243,  11'd273,  11'd304,  11'd334,
    11'd365,  11'd396,  11'd424,  11'd455,  11'd485,  11'd516,
    11'd546,  11'd577,  11'd608,  11'd638,  11'd669,  11'd699,
    11'd730,  11'd761,  11'd790,  11'd821,  11'd851,  11'd882,
    11'd912,  11'd943,  11'd974,  11'd1004, 11'd1035, 11'd1065,
    11'd1096, 11'd1127, 11'd1155, 11'd1186, 11'd1216, 11'd1247,
    11'd1277, 11'd1308, 11'd1339, 11'd1369, 11'd1400, 11'd1430
  };

endpackage

>>> sv/ecd_ifs.sv
`timescale 1ns / 1ps

// timestamp channel
interface ecd_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] epoch_seconds;

  modport source (output valid, output epoch_seconds, input ready);
  modport sink   (input valid, input epoch_seconds, output ready);
endinterface

// civil date channel
interface ecd_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] year;
  logic [3:0]  month_index;
  logic [4:0]  day_index;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;
  logic        saturated;

  modport source (output valid, output year, output month_index, output day_index,
                  output hour, output minute, output second, output saturated,
                  input ready);
  modport sink   (input valid, input year, input month_index, input day_index,
                  input hour, input minute, input second, input saturated,
                  output ready);
endinterface

>>> sv/ecd_month_find.sv
`timescale 1ns / 1ps

module ecd_month_find
  import ecd_pkg::*;
(
  input  logic [10:0] day_of_cycle,
  output logic [5:0]  month_of_cycle
);

  logic [CYCLE_MONTHS-1:1] past_start;

  // one compare per month boundary, gives a thermometer code
  always_comb begin
    for (int g = 1; g < CYCLE_MONTHS; g++) begin
      past_start[g] = (day_of_cycle >= MONTH_START[g]);
    end
  end

  // highest boundary passed is the month
  always_comb begin
    month_of_cycle = '0;
    for (int g = 1; g < CYCLE_MONTHS; g++) begin
      if (past_start[g]) begin
        month_of_cycle = 6'(g);
      end
    end
  end

endmodule

>>> sv/epoch_seconds_to_civil_date.sv
`timescale 1ns / 1ps

// Converts seconds since 1970-01-01 00:00:00 UTC into year, month, day,
// hour, minute and second, valid through 2099-12-31 23:59:59.
// Channels: epoch (sink) carries one timestamp per beat; date (source)
// carries one civil date per beat, valid/ready on both, a beat moves
// when valid and ready are both high at a rising edge of clk.
// Inputs past the end of 2099 are clamped to its last second and the
// result carries saturated = 1.
// Each accepted timestamp passes through the stage registers s1 to s5 and
// the output register before its date appears. Throughput: one beat per
// cycle while date.ready is high; each of the six register stages has at
// most one constant multiplier on its longest path.
// Stalls: when date.ready is low the output register holds its beat and
// earlier stages keep filling until every stage holds data; epoch.ready
// drops only then. Nothing is dropped or repeated.
// Reset: rst (synchronous, active high) clears all stage valid bits and
// holds epoch.ready low; the pipeline is empty and ready in the first
// cycle after reset.
module epoch_seconds_to_civil_date
  import ecd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  ecd_in_if.sink   epoch,
  ecd_out_if.source date
);

  localparam int STAGES = 6;

  logic [STAGES:1]   v;
  logic [STAGES+1:1] adv;
  logic [STAGES:1]   v_up;

  // stage advance chain, a stage loads when empty or when it drains
  always_comb begin
    adv[STAGES+1] = date.ready;
    for (int k = STAGES; k >= 1; k--) begin
      adv[k] = !v[k] || adv[k+1];
    end
  end

  assign v_up = {v[STAGES-1:1], epoch.valid};
  assign epoch.ready = adv[1] && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 1; k <= STAGES; k++) begin
        if (adv[k]) begin
          v[k] <= v_up[k];
        end
      end
    end
  end

  // stage 1: clamp, day count product
  logic [31:0] t_clamped;
  logic        t_sat;
  logic [31:0] s1_t;
  logic        s1_sat;
  logic [50:0] s1_prod;

  always_comb begin
    t_sat     = (epoch.epoch_seconds > LAST_SECOND);
    t_clamped = t_sat ? LAST_SECOND : epoch.epoch_seconds;
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_t    <= t_clamped;
      s1_sat  <= t_sat;
      s1_prod <= t_clamped[31:7] * DAY_RECIP;
    end
  end

  // stage 2: day count and time of day
  logic [15:0] days;
  logic [32:0] day_secs;
  logic [31:0] tod_full;
  logic [15:0] s2_days;
  logic [16:0] s2_tod;
  logic        s2_sat;

  always_comb begin
    days     = s1_prod[50:DAY_SHIFT];
    day_secs = days * SECS_PER_DAY;
    tod_full = s1_t - day_secs[31:0];
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s2_days <= days;
      s2_tod  <= tod_full[16:0];
      s2_sat  <= s1_sat;
    end
  end

  // stage 3: cycle and hour products
  logic [32:0] s3_cyc_prod;
  logic [26:0] s3_hour_prod;
  logic [15:0] s3_days;
  logic [16:0] s3_tod;
  logic        s3_sat;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s3_cyc_prod  <= s2_days * CYC_RECIP;
      s3_hour_prod <= s2_tod[16:4] * HOUR_RECIP;
      s3_days      <= s2_days;
      s3_tod       <= s2_tod;
      s3_sat       <= s2_sat;
    end
  end

  // stage 4: day within cycle, hour, seconds within hour
  logic [5:0]  cycles;
  logic [5:0]  hour_wide;
  logic [16:0] cyc_days;
  logic [15:0] doff_full;
  logic [17:0] hour_secs;
  logic [16:0] remh_full;
  logic [5:0]  s4_cyc;
  logic [10:0] s4_doff;
  logic [4:0]  s4_hour;
  logic [11:0] s4_remh;
  logic        s4_sat;

  always_comb begin
    cycles    = s3_cyc_prod[32:CYC_SHIFT];
    hour_wide = s3_hour_prod[26:HOUR_SHIFT];
    cyc_days  = cycles * DAYS_PER_CYCLE;
    doff_full = s3_days - cyc_days[15:0];
    hour_secs = hour_wide * SECS_PER_HOUR;
    remh_full = s3_tod - hour_secs[16:0];
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s4_cyc  <= cycles;
      s4_doff <= doff_full[10:0];
      s4_hour <= hour_wide[4:0];
      s4_remh <= remh_full[11:0];
      s4_sat  <= s3_sat;
    end
  end

  // stage 5: month of cycle, minute
  logic [5:0]  midx;
  logic [20:0] min_prod;
  logic [6:0]  minute_wide;
  logic [5:0]  s5_midx;
  logic [10:0] s5_doff;
  logic [5:0]  s5_cyc;
  logic [4:0]  s5_hour;
  logic [5:0]  s5_minute;
  logic [11:0] s5_remh;
  logic        s5_sat;

  ecd_month_find u_month_find (
    .day_of_cycle   (s4_doff),
    .month_of_cycle (midx)
  );

  always_comb begin
    min_prod    = s4_remh[11:2] * MIN_RECIP;
    minute_wide = min_prod[20:MIN_SHIFT];
  end

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      s5_midx   <= midx;
      s5_doff   <= s4_doff;
      s5_cyc    <= s4_cyc;
      s5_hour   <= s4_hour;
      s5_minute <= minute_wide[5:0];
      s5_remh   <= s4_remh;
      s5_sat    <= s4_sat;
    end
  end

  // stage 6: year, month, day, second into the output register
  logic [1:0]  year_off;
  logic [5:0]  month_wide;
  logic [10:0] day_wide;
  logic [11:0] year_calc;
  logic [11:0] min_secs;
  logic [11:0] sec_wide;
  logic [11:0] o_year;
  logic [3:0]  o_month;
  logic [4:0]  o_day;
  logic [4:0]  o_hour;
  logic [5:0]  o_minute;
  logic [5:0]  o_second;
  logic        o_sat;

  always_comb begin
    if (s5_midx >= 3 * MONTHS_PER_YEAR) begin
      year_off = 2'd3;
    end else if (s5_midx >= 2 * MONTHS_PER_YEAR) begin
      year_off = 2'd2;
    end else if (s5_midx >= MONTHS_PER_YEAR) begin
      year_off = 2'd1;
    end else begin
      year_off = 2'd0;
    end
    month_wide = s5_midx - 6'(year_off * MONTHS_PER_YEAR);
    day_wide   = s5_doff - MONTH_START[s5_midx];
    year_calc  = BASE_YEAR + {4'd0, s5_cyc, 2'b00} + {10'd0, year_off};
    min_secs   = 12'(s5_minute * SECS_PER_MIN);
    sec_wide   = s5_remh - min_secs;
  end

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      o_year   <= year_calc;
      o_month  <= month_wide[3:0];
      o_day    <= day_wide[4:0];
      o_hour   <= s5_hour;
      o_minute <= s5_minute;
      o_second <= sec_wide[5:0];
      o_sat    <= s5_sat;
    end
  end

  assign date.valid       = v[STAGES];
  assign date.year        = o_year;
  assign date.month_index = o_month;
  assign date.day_index   = o_day;
  assign date.hour        = o_hour;
  assign date.minute      = o_minute;
  assign date.second      = o_second;
  assign date.saturated   = o_sat;

  // checks
  a_fields_in_range: assert property (@(posedge clk) disable iff (rst)
    date.valid |-> (date.month_index <= LAST_MONTH) && (date.day_index <= LAST_DAY) &&
                   (date.hour <= LAST_HOUR) && (date.minute <= LAST_MINSEC) &&
                   (date.second <= LAST_MINSEC) && (date.year <= LAST_YEAR))
    else $error("civil date field out of range");

  a_saturated_is_last_second: assert property (@(posedge clk) disable iff (rst)
    (date.valid && date.saturated) |-> (date.year == LAST_YEAR) &&
      (date.month_index == LAST_MONTH) && (date.day_index == LAST_DAY) &&
      (date.hour == LAST_HOUR) && (date.minute == LAST_MINSEC) &&
      (date.second == LAST_MINSEC))
    else $error("clamped beat is not the last second of 2099");

  a_backpressure_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !epoch.ready |-> ((&v) && !date.ready))
    else $error("input stalled while a stage is empty");

endmodule
